### hdl/mntt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mntt_pkg
// Shared types, constants and helper functions for the note to tone timer.
// ----------------------------------------------------------------------------
package mntt_pkg;

    // Field widths.
    localparam int WORD_W   = 16;
    localparam int PITCH_W  = 4;
    localparam int OCT_W    = 3;
    localparam int UNITS_W  = WORD_W - PITCH_W - OCT_W;
    localparam int CLK_W    = 25;
    localparam int UNIT_W   = 8;
    localparam int TONE_W   = 13;
    localparam int SEL_W    = 3;
    localparam int CMP_W    = 16;
    localparam int DUR_W    = 17;
    localparam int PAUSE_W  = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CLK_W;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_CLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_UNIT = 2'd1;
    localparam logic [CLK_W-1:0]  CPU_CLOCK_RESET = 25'd16000000;
    localparam logic [UNIT_W-1:0] NOTE_UNIT_RESET = 8'd32;

    // Pitch table.
    localparam int PITCH_ENTRIES = 13;
    localparam logic [OCT_W-1:0] TOP_OCTAVE = 3'd7;

    // Divider: half the clock divided by the tone frequency.
    localparam int DVD_W          = CLK_W - 1;
    localparam int DVS_W          = TONE_W;
    localparam int STEPS_PER_STG  = 2;
    localparam int DIV_STAGES     = DVD_W / STEPS_PER_STG;

    // Prescaler selection.
    localparam logic [DVD_W-1:0] COUNT_LIMIT = 24'd65536;
    localparam logic [SEL_W-1:0] PS_STOP   = 3'd0;
    localparam logic [SEL_W-1:0] PS_DIV1   = 3'd1;
    localparam logic [SEL_W-1:0] PS_DIV8   = 3'd2;
    localparam logic [SEL_W-1:0] PS_DIV64  = 3'd3;
    localparam logic [SEL_W-1:0] PS_DIV256 = 3'd4;

    // Everything about a note that rides alongside the division.
    typedef struct packed {
        logic                 eom;
        logic [TONE_W-1:0]    tone_hz;
        logic [DUR_W-1:0]     duration_ms;
        logic [PAUSE_W-1:0]   pause_ms;
    } note_info_t;

    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [DVD_W-1:0] dq;
    } div_state_t;

    function automatic logic [TONE_W-1:0] pitch_freq(input logic [PITCH_W-1:0] pitch);
        logic [TONE_W-1:0] f;
        case (pitch)
            4'd1:    f = 13'd4186;
            4'd2:    f = 13'd4435;
            4'd3:    f = 13'd4698;
            4'd4:    f = 13'd4978;
            4'd5:    f = 13'd5274;
            4'd6:    f = 13'd5588;
            4'd7:    f = 13'd5920;
            4'd8:    f = 13'd6272;
            4'd9:    f = 13'd6665;
            4'd10:   f = 13'd6880;
            4'd11:   f = 13'd7458;
            4'd12:   f = 13'd7902;
            default: f = '0;
        endcase
        return f;
    endfunction

    // One restoring division step: the next dividend bit enters the
    // remainder and the quotient bit enters at the bottom of dq.
    function automatic div_state_t div_step(input div_state_t s, input logic [DVS_W-1:0] d);
        logic [DVS_W:0] t;
        div_state_t     r;
        t = {s.rem, s.dq[DVD_W-1]};
        if (t >= {1'b0, d}) begin
            r.rem = DVS_W'(t - {1'b0, d});
            r.dq  = {s.dq[DVD_W-2:0], 1'b1};
        end
        else begin
            r.rem = t[DVS_W-1:0];
            r.dq  = {s.dq[DVD_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### hdl/mntt_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mntt_decode
// First stage: unpacks the note word, looks up and shifts the pitch, and
// forms the duration and pause.
// ----------------------------------------------------------------------------
module mntt_decode (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [mntt_pkg::WORD_W-1:0]         note_word,
    input  logic [mntt_pkg::CLK_W-1:0]          cpu_clock_hz,
    input  logic [mntt_pkg::UNIT_W-1:0]         note_unit_ms,
    output logic                                dec_valid,
    output logic [mntt_pkg::DVD_W-1:0]          dec_dividend,
    output mntt_pkg::note_info_t                dec_info
);

    logic [mntt_pkg::PITCH_W-1:0] pitch;
    logic [mntt_pkg::OCT_W-1:0]   octave;
    logic [mntt_pkg::UNITS_W-1:0] units;
    logic [mntt_pkg::OCT_W-1:0]   shamt;
    logic                         eom;

    logic                         valid_reg;
    logic [mntt_pkg::DVD_W-1:0]   dividend_reg;
    mntt_pkg::note_info_t         info_reg;
    mntt_pkg::note_info_t         info_next;

    assign pitch  = note_word[mntt_pkg::PITCH_W-1:0];
    assign octave = note_word[mntt_pkg::PITCH_W +: mntt_pkg::OCT_W];
    assign units  = note_word[mntt_pkg::WORD_W-1 -: mntt_pkg::UNITS_W];
    assign shamt  = mntt_pkg::TOP_OCTAVE - octave;
    assign eom    = (note_word == '0);

    always_comb
    begin
        info_next.eom = eom;
        if (eom || (32'(pitch) >= mntt_pkg::PITCH_ENTRIES)) begin
            info_next.tone_hz = '0;
        end
        else begin
            info_next.tone_hz = mntt_pkg::pitch_freq(pitch) >> shamt;
        end
        info_next.duration_ms = mntt_pkg::DUR_W'(units) * mntt_pkg::DUR_W'(note_unit_ms);
        // The end of melody clears every other field, the pause included.
        info_next.pause_ms = eom ? '0 : note_unit_ms[mntt_pkg::UNIT_W-1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            dividend_reg <= cpu_clock_hz[mntt_pkg::CLK_W-1:1];
            info_reg     <= info_next;
        end
    end

    assign dec_valid    = valid_reg;
    assign dec_dividend = dividend_reg;
    assign dec_info     = info_reg;

endmodule

### hdl/mntt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mntt_div
// Pipelined restoring divider: a few quotient bits per stage, with the note
// information carried along each stage.
// ----------------------------------------------------------------------------
module mntt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mntt_pkg::DVD_W-1:0]    in_dividend,
    input  mntt_pkg::note_info_t          in_info,
    output logic                          div_valid,
    output logic [mntt_pkg::DVD_W-1:0]    div_quotient,
    output mntt_pkg::note_info_t          div_info
);

    logic                          v_reg    [mntt_pkg::DIV_STAGES];
    mntt_pkg::div_state_t          st_reg   [mntt_pkg::DIV_STAGES];
    mntt_pkg::note_info_t          info_reg [mntt_pkg::DIV_STAGES];

    for (genvar s = 0; s < mntt_pkg::DIV_STAGES; s++) begin : g_stage
        logic                  v_in;
        mntt_pkg::div_state_t  st_in;
        mntt_pkg::note_info_t  info_in;
        mntt_pkg::div_state_t  st_next;

        if (s == 0) begin : g_first
            assign v_in     = in_valid;
            assign st_in    = '{rem: '0, dq: in_dividend};
            assign info_in  = in_info;
        end
        else begin : g_rest
            assign v_in     = v_reg[s-1];
            assign st_in    = st_reg[s-1];
            assign info_in  = info_reg[s-1];
        end

        always_comb
        begin
            st_next = st_in;
            for (int k = 0; k < mntt_pkg::STEPS_PER_STG; k++) begin
                st_next = mntt_pkg::div_step(st_next, info_in.tone_hz);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[s] <= 1'b0;
            end
            else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                st_reg[s]   <= st_next;
                info_reg[s] <= info_in;
            end
        end
    end

    assign div_valid    = v_reg[mntt_pkg::DIV_STAGES-1];
    assign div_quotient = st_reg[mntt_pkg::DIV_STAGES-1].dq;
    assign div_info     = info_reg[mntt_pkg::DIV_STAGES-1];

endmodule

### hdl/mntt_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mntt_scale
// Last stage: picks the prescaler, forms the compare value and holds the
// result item in the output register.
// ----------------------------------------------------------------------------
module mntt_scale (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [mntt_pkg::DVD_W-1:0]         quotient,
    input  mntt_pkg::note_info_t               info,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic                               end_of_melody,
    output logic                               is_rest,
    output logic [mntt_pkg::TONE_W-1:0]        tone_hz,
    output logic [mntt_pkg::SEL_W-1:0]         prescale_select,
    output logic [mntt_pkg::CMP_W-1:0]         compare_value,
    output logic [mntt_pkg::DUR_W-1:0]         duration_ms,
    output logic [mntt_pkg::PAUSE_W-1:0]       pause_ms
);

    logic                          load;
    logic                          rest;
    logic [mntt_pkg::DVD_W-1:0]    cnt8;
    logic [mntt_pkg::DVD_W-1:0]    cnt64;
    logic [mntt_pkg::DVD_W-1:0]    count;
    logic [mntt_pkg::SEL_W-1:0]    sel_next;
    logic [mntt_pkg::CMP_W-1:0]    cmp_next;

    logic                          valid_reg;
    logic                          eom_reg;
    logic                          rest_reg;
    logic [mntt_pkg::TONE_W-1:0]   tone_reg;
    logic [mntt_pkg::SEL_W-1:0]    sel_reg;
    logic [mntt_pkg::CMP_W-1:0]    cmp_reg;
    logic [mntt_pkg::DUR_W-1:0]    dur_reg;
    logic [mntt_pkg::PAUSE_W-1:0]  pause_reg;

    assign load  = !(valid_reg && out_stall);
    assign rest  = (info.tone_hz == '0);
    assign cnt8  = quotient >> 3;
    assign cnt64 = quotient >> 6;

    always_comb
    begin
        if (quotient <= mntt_pkg::COUNT_LIMIT) begin
            count    = quotient;
            sel_next = mntt_pkg::PS_DIV1;
        end
        else if (cnt8 <= mntt_pkg::COUNT_LIMIT) begin
            count    = cnt8;
            sel_next = mntt_pkg::PS_DIV8;
        end
        else if (cnt64 <= mntt_pkg::COUNT_LIMIT) begin
            count    = cnt64;
            sel_next = mntt_pkg::PS_DIV64;
        end
        else begin
            count    = quotient >> 8;
            sel_next = mntt_pkg::PS_DIV256;
        end
        // A count of zero wraps to all ones, as the timer register would.
        cmp_next = count[mntt_pkg::CMP_W-1:0] - mntt_pkg::CMP_W'(1);
        if (rest) begin
            sel_next = mntt_pkg::PS_STOP;
            cmp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid) begin
            eom_reg   <= info.eom;
            rest_reg  <= rest && !info.eom;
            tone_reg  <= info.tone_hz;
            sel_reg   <= sel_next;
            cmp_reg   <= cmp_next;
            dur_reg   <= info.duration_ms;
            pause_reg <= info.pause_ms;
        end
    end

    assign out_valid       = valid_reg;
    assign end_of_melody   = eom_reg;
    assign is_rest         = rest_reg;
    assign tone_hz         = tone_reg;
    assign prescale_select = sel_reg;
    assign compare_value   = cmp_reg;
    assign duration_ms     = dur_reg;
    assign pause_ms        = pause_reg;

endmodule

### hdl/melody_note_to_tone_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_note_to_tone_timer
// Turns a packed melody note word into tone timer settings: frequency,
// prescaler select, compare value, duration and pause.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  note_word
//  output    out        out_valid / out_stall end_of_melody .. pause_ms
//  config    in         wr_en                wr_index, wr_data
//
// One item is accepted per cycle unless stalled. Stages: one decode stage,
// twelve divider stages at two quotient bits each, and the output register.
// Reset clears the valid bits and loads the register defaults; no clearing
// pass is needed. While a result waits, the pipeline still fills until its
// last divider stage holds an item; only then is in_stall raised.
// ----------------------------------------------------------------------------
module melody_note_to_tone_timer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [mntt_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [mntt_pkg::CFG_DATA_W-1:0]      wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mntt_pkg::WORD_W-1:0]          note_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 end_of_melody,
    output logic                                 is_rest,
    output logic [mntt_pkg::TONE_W-1:0]          tone_hz,
    output logic [mntt_pkg::SEL_W-1:0]           prescale_select,
    output logic [mntt_pkg::CMP_W-1:0]           compare_value,
    output logic [mntt_pkg::DUR_W-1:0]           duration_ms,
    output logic [mntt_pkg::PAUSE_W-1:0]         pause_ms
);

    logic [mntt_pkg::CLK_W-1:0]   cpu_clock_reg;
    logic [mntt_pkg::UNIT_W-1:0]  note_unit_reg;

    logic                         pipe_en;
    logic                         dec_valid;
    logic [mntt_pkg::DVD_W-1:0]   dec_dividend;
    mntt_pkg::note_info_t         dec_info;
    logic                         div_valid;
    logic [mntt_pkg::DVD_W-1:0]   div_quotient;
    mntt_pkg::note_info_t         div_info;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cpu_clock_reg <= mntt_pkg::CPU_CLOCK_RESET;
            note_unit_reg <= mntt_pkg::NOTE_UNIT_RESET;
        end
        else if (wr_en) begin
            case (wr_index)
                mntt_pkg::REG_CPU_CLOCK: cpu_clock_reg <= wr_data;
                mntt_pkg::REG_NOTE_UNIT: note_unit_reg <= wr_data[mntt_pkg::UNIT_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline freezes only when its last stage cannot hand over.
    assign pipe_en  = !(div_valid && out_valid && out_stall);
    assign in_stall = !pipe_en;

    mntt_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (pipe_en),
        .in_valid     (in_valid),
        .note_word    (note_word),
        .cpu_clock_hz (cpu_clock_reg),
        .note_unit_ms (note_unit_reg),
        .dec_valid    (dec_valid),
        .dec_dividend (dec_dividend),
        .dec_info     (dec_info)
    );

    mntt_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (pipe_en),
        .in_valid     (dec_valid),
        .in_dividend  (dec_dividend),
        .in_info      (dec_info),
        .div_valid    (div_valid),
        .div_quotient (div_quotient),
        .div_info     (div_info)
    );

    mntt_scale u_scale (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (div_valid),
        .quotient        (div_quotient),
        .info            (div_info),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .end_of_melody   (end_of_melody),
        .is_rest         (is_rest),
        .tone_hz         (tone_hz),
        .prescale_select (prescale_select),
        .compare_value   (compare_value),
        .duration_ms     (duration_ms),
        .pause_ms        (pause_ms)
    );

endmodule

### hdl/mntt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mntt_checker
// Port-level checks for the note to tone timer, bound to the top level.
// ----------------------------------------------------------------------------
module mntt_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_stall,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 end_of_melody,
    input  logic                                 is_rest,
    input  logic [mntt_pkg::TONE_W-1:0]          tone_hz,
    input  logic [mntt_pkg::SEL_W-1:0]           prescale_select,
    input  logic [mntt_pkg::CMP_W-1:0]           compare_value,
    input  logic [mntt_pkg::DUR_W-1:0]           duration_ms,
    input  logic [mntt_pkg::PAUSE_W-1:0]         pause_ms
);

    // The end of melody item carries nothing else.
    a_eom_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_melody |->
            !is_rest && tone_hz == '0 && prescale_select == mntt_pkg::PS_STOP &&
            compare_value == '0 && duration_ms == '0 && pause_ms == '0)
        else $error("end of melody item has nonzero fields");

    // A rest stops the timer.
    a_rest_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_rest |->
            tone_hz == '0 && prescale_select == mntt_pkg::PS_STOP && compare_value == '0)
        else $error("rest item does not stop the timer");

    // A sounding note has a tone and a running prescaler.
    a_tone_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_rest && !end_of_melody |->
            tone_hz != '0 &&
            (prescale_select == mntt_pkg::PS_DIV1 || prescale_select == mntt_pkg::PS_DIV8 ||
             prescale_select == mntt_pkg::PS_DIV64 || prescale_select == mntt_pkg::PS_DIV256))
        else $error("sounding note without tone or prescaler");

    // Input back-pressure only comes from a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(compare_value) && $stable(duration_ms) &&
            $stable(prescale_select) && $stable(tone_hz))
        else $error("stalled result changed");

endmodule

bind melody_note_to_tone_timer mntt_checker u_mntt_checker (.*);

### tb/melody_note_to_tone_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_note_to_tone_timer_tb
// Feeds note words to the tone timer and checks each result against a
// behavioral model of the tone lookup, the prescaler search and the duration
// math. Registers change between phases while the pipeline is empty. Both
// sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module melody_note_to_tone_timer_tb;

    import mntt_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int NOTES_PER_PHASE = 220;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic                end_of_melody;
        logic                is_rest;
        logic [TONE_W-1:0]   tone_hz;
        logic [SEL_W-1:0]    prescale_select;
        logic [CMP_W-1:0]    compare_value;
        logic [DUR_W-1:0]    duration_ms;
        logic [PAUSE_W-1:0]  pause_ms;
    } tone_setting_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    wr_index = '0;
    logic [CFG_DATA_W-1:0]   wr_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [WORD_W-1:0]       note_word = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    end_of_melody;
    logic                    is_rest;
    logic [TONE_W-1:0]       tone_hz;
    logic [SEL_W-1:0]        prescale_select;
    logic [CMP_W-1:0]        compare_value;
    logic [DUR_W-1:0]        duration_ms;
    logic [PAUSE_W-1:0]      pause_ms;

    // Register shadows used by the tone model.
    logic [CLK_W-1:0]        cpu_clock_cfg = CPU_CLOCK_RESET;
    logic [UNIT_W-1:0]       note_unit_cfg = NOTE_UNIT_RESET;
    logic [TONE_W-1:0]       fifth_octave_hz [16];

    logic [WORD_W-1:0]       pending_notes [$];
    tone_setting_t           expected_tones [$];
    int unsigned             notes_issued = 0;
    int unsigned             notes_accepted = 0;
    int unsigned             quiet_cycles = 0;
    int unsigned             mismatches = 0;
    int unsigned             send_idle_pct = 0;
    int unsigned             recv_stall_pct = 0;

    melody_note_to_tone_timer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .note_word       (note_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .end_of_melody   (end_of_melody),
        .is_rest         (is_rest),
        .tone_hz         (tone_hz),
        .prescale_select (prescale_select),
        .compare_value   (compare_value),
        .duration_ms     (duration_ms),
        .pause_ms        (pause_ms)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic tone_setting_t predict_tone(input logic [WORD_W-1:0] w);
        tone_setting_t      r;
        logic [PITCH_W-1:0] pitch;
        logic [OCT_W-1:0]   octave;
        logic [UNITS_W-1:0] units;
        logic [TONE_W-1:0]  freq;
        logic [31:0]        count;
        r = '0;
        if (w == '0)
        begin
            r.end_of_melody = 1'b1;
            return r;
        end
        pitch  = w[PITCH_W-1:0];
        octave = w[PITCH_W +: OCT_W];
        units  = w[WORD_W-1 -: UNITS_W];
        freq   = '0;
        if (pitch < PITCH_ENTRIES)
        begin
            freq = fifth_octave_hz[pitch] >> (TOP_OCTAVE - octave);
        end
        r.is_rest = (freq == '0);
        r.tone_hz = freq;
        if (freq != '0)
        begin
            count = (32'(cpu_clock_cfg) >> 1) / 32'(freq);
            r.prescale_select = PS_DIV1;
            if (count > 32'(COUNT_LIMIT))
            begin
                r.prescale_select = PS_DIV8;
                count = count >> 3;
            end
            if (count > 32'(COUNT_LIMIT))
            begin
                r.prescale_select = PS_DIV64;
                count = count >> 3;
            end
            if (count > 32'(COUNT_LIMIT))
            begin
                r.prescale_select = PS_DIV256;
                count = count >> 2;
            end
            r.compare_value = CMP_W'(count - 32'd1);
        end
        r.duration_ms = DUR_W'(32'(units) * 32'(note_unit_cfg));
        r.pause_ms    = PAUSE_W'(note_unit_cfg >> 1);
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender: a new item goes out only once the previous one was taken.
    always @(negedge clk)
    begin
        if (notes_accepted == notes_issued)
        begin
            if (pending_notes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid     <= 1'b1;
                note_word    <= pending_notes.pop_front();
                notes_issued <= notes_issued + 1;
            end
            else
            begin
                in_valid  <= 1'b0;
                note_word <= WORD_W'($urandom);
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Both handshakes are sampled here, along with the watchdog.
    always @(posedge clk)
    begin
        tone_setting_t want;
        if (in_valid && !in_stall)
        begin
            expected_tones.push_back(predict_tone(note_word));
            notes_accepted <= notes_accepted + 1;
        end
        if (out_valid && !out_stall)
        begin
            if (expected_tones.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got word %h", $time,
                         {end_of_melody, is_rest, tone_hz, prescale_select,
                          compare_value, duration_ms, pause_ms});
                mismatches++;
            end
            else
            begin
                want = expected_tones.pop_front();
                compare_field("end_of_melody", want.end_of_melody, end_of_melody);
                compare_field("is_rest", want.is_rest, is_rest);
                compare_field("tone_hz", want.tone_hz, tone_hz);
                compare_field("prescale_select", want.prescale_select, prescale_select);
                compare_field("compare_value", want.compare_value, compare_value);
                compare_field("duration_ms", want.duration_ms, duration_ms);
                compare_field("pause_ms", want.pause_ms, pause_ms);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_notes.size() != 0 || notes_issued != notes_accepted ||
               expected_tones.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        case (index)
            REG_CPU_CLOCK: cpu_clock_cfg = data[CLK_W-1:0];
            REG_NOTE_UNIT: note_unit_cfg = data[UNIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic push_random_notes(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 4)
                pending_notes.push_back('0);
            else
                pending_notes.push_back(WORD_W'($urandom));
        end
    endtask

    initial
    begin
        logic [CLK_W-1:0]      cpu_setting;
        logic [UNIT_W-1:0]     unit_setting;
        logic [CFG_DATA_W-1:0] unit_data;
        fifth_octave_hz = '{13'd0, 13'd4186, 13'd4435, 13'd4698, 13'd4978, 13'd5274,
                            13'd5588, 13'd5920, 13'd6272, 13'd6665, 13'd6880, 13'd7458,
                            13'd7902, 13'd0, 13'd0, 13'd0};
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Sender and receiver swap roles after the first three phases, then
            // both run flat out in the last two.
            if (phase < 3)
            begin
                send_idle_pct  = 28;
                recv_stall_pct = 51;
            end
            else if (phase < 6)
            begin
                send_idle_pct  = 51;
                recv_stall_pct = 28;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            case (phase)
                1: begin cpu_setting = 25'd1000000; unit_setting = 8'd1; end
                2: begin cpu_setting = 25'd32000000; unit_setting = 8'd255; end
                3: begin cpu_setting = '1; unit_setting = 8'd0; end
                4: begin cpu_setting = 25'd1; unit_setting = 8'd128; end
                5: begin
                    cpu_setting  = CLK_W'($urandom_range(32000000, 1000000));
                    unit_setting = UNIT_W'($urandom_range(255, 1));
                end
                6: begin
                    cpu_setting  = CLK_W'($urandom_range(20000, 0));
                    unit_setting = UNIT_W'($urandom);
                end
                default: begin
                    cpu_setting  = CPU_CLOCK_RESET;
                    unit_setting = NOTE_UNIT_RESET;
                end
            endcase

            if (phase != 0)
            begin
                // Junk in the upper data bits must be dropped by the unit register.
                unit_data = CFG_DATA_W'($urandom);
                unit_data[UNIT_W-1:0] = unit_setting;
                write_reg(REG_CPU_CLOCK, CFG_DATA_W'(cpu_setting));
                write_reg(REG_NOTE_UNIT, unit_data);
                if (phase == 4)
                begin
                    write_reg(REG_NONE, CFG_DATA_W'($urandom));
                end
            end

            if (phase == 0)
            begin
                // Field extremes, every table pitch, rests and the end marker.
                pending_notes.push_back(16'h0000);
                pending_notes.push_back(16'hFFFF);
                pending_notes.push_back({9'd1, 3'd3, 4'd0});
                pending_notes.push_back({9'd5, 3'd7, 4'd13});
                pending_notes.push_back({9'd511, 3'd2, 4'd14});
                pending_notes.push_back({9'd2, 3'd0, 4'd15});
                for (int p = 1; p < PITCH_ENTRIES; p++)
                begin
                    pending_notes.push_back({9'(p * 40), 3'(p % 8), 4'(p)});
                end
                pending_notes.push_back({9'd511, 3'd7, 4'd12});
                pending_notes.push_back(16'h0000);
                pending_notes.push_back({9'd1, 3'd0, 4'd1});
                pending_notes.push_back({9'd0, 3'd7, 4'd1});
                pending_notes.push_back({9'd0, 3'd0, 4'd12});
            end

            if (phase == 1)
            begin
                // The sender holds off mid-phase until the pipeline is empty.
                push_random_notes(NOTES_PER_PHASE / 2);
                wait_drained();
                push_random_notes(NOTES_PER_PHASE - NOTES_PER_PHASE / 2);
            end
            else
            begin
                push_random_notes(NOTES_PER_PHASE);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
